// File: rtl/slcd_pkg.sv
// Package for the 14-segment LCD character writer.
// Holds the glyph tables, the position-to-bit map, the FSM type and the command struct.
// No dependencies.
package slcd_pkg;

    localparam int NUM_WORDS   = 8;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 3;
    localparam int NUM_SLOTS   = 6;
    localparam int GLYPH_W     = 16;
    localparam int LOC_W       = 6;

    localparam logic [GLYPH_W-1:0] POINT_MASK = 16'h0002;
    localparam logic [GLYPH_W-1:0] COLON_MASK = 16'h0020;
    localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd7;

    localparam logic [GLYPH_W-1:0] LETTER_GLYPH [26] = '{
        16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
        16'hFA00, 16'h0014, 16'h5300, 16'h9841, 16'h1900, 16'h5A48, 16'h5A09,
        16'h5F00, 16'hFC00, 16'h5F01, 16'hFC01, 16'hAF00, 16'h0414, 16'h5B00,
        16'h18C0, 16'h5A81, 16'h00C9, 16'h0058, 16'h05C0
    };

    localparam logic [GLYPH_W-1:0] NUMBER_GLYPH [10] = '{
        16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00,
        16'hAF00, 16'hBF00, 16'h4600, 16'hFF00, 16'hEF00
    };

    // bit 5 selects the odd word of the pair, bits 4:0 the bit in that word
    localparam logic [LOC_W-1:0] SLOT_LOC [NUM_SLOTS][4] = '{
        '{6'd4,  6'd23, 6'd22, 6'd3 },
        '{6'd6,  6'd13, 6'd12, 6'd5 },
        '{6'd15, 6'd29, 6'd28, 6'd14},
        '{6'd31, 6'd33, 6'd32, 6'd30},
        '{6'd35, 6'd25, 6'd24, 6'd34},
        '{6'd17, 6'd8,  6'd9,  6'd26}
    };

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    typedef struct packed {
        logic             upd;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        unique case (c)
            8'h20: return 16'h0000;
            8'h2A: return 16'hA0DD;
            8'h28: return 16'h0028;
            8'h29: return 16'h0011;
            8'h64: return 16'hF300;
            8'h6D: return 16'hB210;
            8'h6E: return 16'h2210;
            8'hB5: return 16'h6084;
            8'h2D: return 16'hA000;
            8'h2B: return 16'hA014;
            8'h2F: return 16'h00C0;
            8'hB0: return 16'hEC00;
            8'h25: return 16'hB300;
            8'hFF: return 16'hFFDD;
            default: d = 8'h00;
        endcase
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return NUMBER_GLYPH[d[3:0]];
        end
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            return LETTER_GLYPH[d[4:0]];
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61;
            return LETTER_GLYPH[d[4:0]];
        end
        return 16'h0000;
    endfunction

endpackage

// File: rtl/slcd_if.sv
// Channel interfaces for the 14-segment LCD character writer.
// Depends on slcd_pkg for widths.
interface slcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       dot_en;
    logic       col_en;
    logic [2:0] digit_slot;

    modport source (output valid, char_code, dot_en, col_en, digit_slot, input ready);
    modport sink   (input valid, char_code, dot_en, col_en, digit_slot, output ready);
endinterface

interface slcd_out_if;
    logic                           valid;
    logic                           ready;
    logic [slcd_pkg::IDX_W-1:0]     word_index;
    logic [slcd_pkg::WORD_W-1:0]    word_value;
    logic                           last_word;

    modport source (output valid, word_index, word_value, last_word, input ready);
    modport sink   (input valid, word_index, word_value, last_word, output ready);
endinterface

// File: rtl/slcd_ctrl.sv
// Controller for the 14-segment LCD character writer.
// Sequences one update and eight word transactions; depends on slcd_pkg.
module slcd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output slcd_pkg::t_cmd   o_cmd
);

    slcd_pkg::t_state              r_state, n_state;
    logic [slcd_pkg::IDX_W-1:0]    r_cnt, n_cnt;
    logic                          in_hs, out_hs;

    assign o_in_ready  = (r_state == slcd_pkg::S_IDLE);
    assign o_out_valid = (r_state == slcd_pkg::S_EMIT);
    assign in_hs       = i_in_valid && o_in_ready;
    assign out_hs      = o_out_valid && i_out_ready;
    assign o_cmd.upd   = in_hs;
    assign o_cmd.idx   = r_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            slcd_pkg::S_IDLE: begin
                if (in_hs) begin
                    n_state = slcd_pkg::S_EMIT;
                    n_cnt   = '0;
                end
            end
            slcd_pkg::S_EMIT: begin
                if (out_hs) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == slcd_pkg::LAST_IDX) begin
                        n_state = slcd_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = slcd_pkg::S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slcd_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_accept_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_hs |=> (o_out_valid && r_cnt == '0))
        else $error("accepted transaction did not start emission at word 0");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_hs && r_cnt == slcd_pkg::LAST_IDX) |=> o_in_ready)
        else $error("not ready after last word");

    a_stall_holds_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_cnt)))
        else $error("word index moved while stalled");

endmodule

// File: rtl/slcd_dp.sv
// Datapath for the 14-segment LCD character writer.
// Holds the display memory, scatters glyph nibbles into it and selects the output word.
// Depends on slcd_pkg.
module slcd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slcd_pkg::t_cmd                i_cmd,
    input  logic [7:0]                    i_char_code,
    input  logic                          i_dot_en,
    input  logic                          i_col_en,
    input  logic [2:0]                    i_digit_slot,
    output logic [slcd_pkg::IDX_W-1:0]    o_word_index,
    output logic [slcd_pkg::WORD_W-1:0]   o_word_value,
    output logic                          o_last_word
);

    logic [slcd_pkg::NUM_WORDS-1:0][slcd_pkg::WORD_W-1:0] r_mem, n_mem;
    logic [slcd_pkg::GLYPH_W-1:0] glyph;
    logic [3:0]                   nib;
    logic [slcd_pkg::LOC_W-1:0]   loc;
    logic [slcd_pkg::IDX_W-1:0]   w;
    logic                         slot_ok;

    assign slot_ok = (i_digit_slot < 3'(slcd_pkg::NUM_SLOTS));

    always_comb begin
        glyph = slcd_pkg::glyph_of(i_char_code);
        if (i_dot_en) glyph = glyph | slcd_pkg::POINT_MASK;
        if (i_col_en) glyph = glyph | slcd_pkg::COLON_MASK;
    end

    always_comb begin
        n_mem = r_mem;
        nib   = '0;
        loc   = '0;
        w     = '0;
        if (i_cmd.upd && slot_ok) begin
            for (int k = 0; k < 4; k++) begin
                nib = glyph[slcd_pkg::GLYPH_W-1-4*k -: 4];
                for (int b = 0; b < 4; b++) begin
                    loc = slcd_pkg::SLOT_LOC[i_digit_slot][b];
                    w   = {2'(k), loc[5]};
                    n_mem[w][loc[4:0]] = nib[b];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem <= '0;
        end else begin
            r_mem <= n_mem;
        end
    end

    assign o_word_index = i_cmd.idx;
    assign o_word_value = r_mem[i_cmd.idx];
    assign o_last_word  = (i_cmd.idx == slcd_pkg::LAST_IDX);

    a_hold_without_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.upd |=> $stable(r_mem))
        else $error("display memory changed without an update");

    a_bad_slot_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && !slot_ok) |=> $stable(r_mem))
        else $error("out-of-range position changed display memory");

    a_single_word_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && slot_ok && i_digit_slot != 3'd3 && i_digit_slot != 3'd4)
        |=> ($stable(r_mem[1]) && $stable(r_mem[3]) && $stable(r_mem[5])
             && $stable(r_mem[7])))
        else $error("odd word changed for a position that maps to even words only");

endmodule

// File: rtl/segment_lcd_char_writer_top.sv
// Top level of the 14-segment LCD character writer.
// Joins slcd_ctrl and slcd_dp; depends on slcd_pkg and slcd_if.
//
// Usage:
//   i_in  carries one character transaction: char_code, dot_en, col_en
//         and digit_slot. It is taken when valid and ready are both high.
//   o_out carries the display memory afterwards: eight transactions with
//         word_index 0 to 7, word_value, and last_word high on index 7.
// Timing: the character is scattered into the display memory in the cycle
//   it is taken; word 0 is offered the next cycle and one word per cycle
//   follows while o_out is ready. A new character is not taken until all
//   eight words of the previous one have gone out through the single
//   output word port of the display memory.
// Reset: i_rst_n low clears the display memory to blank and returns the
//   block to idle with i_in ready.
// Stall: with o_out ready low the current word and its index hold; i_in
//   stays not ready until the eighth word has gone.
module segment_lcd_char_writer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slcd_in_if.sink      i_in,
    slcd_out_if.source   o_out
);

    slcd_pkg::t_cmd cmd;

    slcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    slcd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_char_code  (i_in.char_code),
        .i_dot_en     (i_in.dot_en),
        .i_col_en     (i_in.col_en),
        .i_digit_slot (i_in.digit_slot),
        .o_word_index (o_out.word_index),
        .o_word_value (o_out.word_value),
        .o_last_word  (o_out.last_word)
    );

endmodule

// File: tb/tb_segment_lcd_char_writer_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for segment_lcd_char_writer_top: directed rows, then random characters.
// Depends on slcd_pkg, slcd_if and the RTL of the top level.
module tb_segment_lcd_char_writer_top;

    localparam int WDOG_LIMIT = 2000;
    localparam int HOLD_LEN   = 80;
    localparam int N_RANDOM   = 285;
    localparam int N_DIR      = 25;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LOW_D  = 8'h64;
    localparam logic [7:0] CH_LOW_M  = 8'h6D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_MICRO  = 8'hB5;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DEGREE = 8'hB0;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_ALL    = 8'hFF;

    localparam logic [15:0] DP_SEG    = 16'h0002;
    localparam logic [15:0] COLON_SEG = 16'h0020;

    localparam logic [15:0] ALPHA_SEG [26] = '{
        16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
        16'hFA00, 16'h0014, 16'h5300, 16'h9841, 16'h1900, 16'h5A48, 16'h5A09,
        16'h5F00, 16'hFC00, 16'h5F01, 16'hFC01, 16'hAF00, 16'h0414, 16'h5B00,
        16'h18C0, 16'h5A81, 16'h00C9, 16'h0058, 16'h05C0
    };
    localparam logic [15:0] DIGIT_SEG [10] = '{
        16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00,
        16'hAF00, 16'hBF00, 16'h4600, 16'hFF00, 16'hEF00
    };
    // 0..31: bit of word 2k; 32..63: bit of word 2k+1
    localparam int SEG_BIT_MAP [6][4] = '{
        '{4, 23, 22, 3}, '{6, 13, 12, 5}, '{15, 29, 28, 14},
        '{31, 33, 32, 30}, '{35, 25, 24, 34}, '{17, 8, 9, 26}
    };
    localparam logic [7:0] SYMBOL_CODES [11] = '{
        CH_SPACE, CH_STAR, CH_LPAREN, CH_RPAREN, CH_MINUS, CH_PLUS,
        CH_SLASH, CH_PCT, CH_MICRO, CH_DEGREE, CH_ALL
    };

    typedef struct packed {
        logic [7:0] code;
        logic       pt;
        logic       col;
        logic [2:0] slot;
        logic       blank_exp;
    } t_dir_row;

    typedef struct {
        logic [slcd_pkg::IDX_W-1:0]  idx;
        logic [slcd_pkg::WORD_W-1:0] value;
        logic                        last;
    } t_word_exp;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{8'h41, 1'b0, 1'b0, 3'd6, 1'b1},
        '{CH_ALL, 1'b1, 1'b1, 3'd7, 1'b1},
        '{8'h00, 1'b0, 1'b0, 3'd6, 1'b1},
        '{CH_SPACE, 1'b0, 1'b0, 3'd0, 1'b1},
        '{CH_ALL, 1'b1, 1'b1, 3'd0, 1'b0},
        '{CH_ALL, 1'b1, 1'b1, 3'd1, 1'b0},
        '{CH_ALL, 1'b1, 1'b1, 3'd2, 1'b0},
        '{CH_ALL, 1'b1, 1'b1, 3'd3, 1'b0},
        '{CH_ALL, 1'b1, 1'b1, 3'd4, 1'b0},
        '{CH_ALL, 1'b1, 1'b1, 3'd5, 1'b0},
        '{8'h00, 1'b0, 1'b0, 3'd3, 1'b0},
        '{8'h01, 1'b1, 1'b0, 3'd4, 1'b0},
        '{8'h80, 1'b0, 1'b1, 3'd5, 1'b0},
        '{8'h30, 1'b0, 1'b0, 3'd0, 1'b0},
        '{8'h39, 1'b1, 1'b0, 3'd1, 1'b0},
        '{8'h5A, 1'b0, 1'b1, 3'd2, 1'b0},
        '{8'h61, 1'b0, 1'b0, 3'd3, 1'b0},
        '{CH_LOW_D, 1'b0, 1'b0, 3'd4, 1'b0},
        '{CH_LOW_M, 1'b1, 1'b1, 3'd5, 1'b0},
        '{CH_LOW_N, 1'b0, 1'b0, 3'd0, 1'b0},
        '{8'h7A, 1'b0, 1'b0, 3'd1, 1'b0},
        '{CH_MICRO, 1'b0, 1'b0, 3'd2, 1'b0},
        '{CH_DEGREE, 1'b0, 1'b0, 3'd3, 1'b0},
        '{CH_STAR, 1'b0, 1'b0, 3'd4, 1'b0},
        '{CH_PCT, 1'b1, 1'b0, 3'd5, 1'b0}
    };

    logic clk;
    logic rst_n;

    slcd_in_if  in_ch ();
    slcd_out_if out_ch ();

    segment_lcd_char_writer_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [slcd_pkg::WORD_W-1:0] lcd_ram [slcd_pkg::NUM_WORDS];
    t_word_exp         word_q [$];
    int                err_cnt;
    int                chars_sent;
    int                words_checked;
    int                stall_left;
    int                idle_cycles;
    bit                calm;
    bit                hold_req;

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] seg_glyph(input logic [7:0] code);
        unique case (code)
            CH_SPACE:  return 16'h0000;
            CH_STAR:   return 16'hA0DD;
            CH_LPAREN: return 16'h0028;
            CH_RPAREN: return 16'h0011;
            CH_LOW_D:  return 16'hF300;
            CH_LOW_M:  return 16'hB210;
            CH_LOW_N:  return 16'h2210;
            CH_MICRO:  return 16'h6084;
            CH_MINUS:  return 16'hA000;
            CH_PLUS:   return 16'hA014;
            CH_SLASH:  return 16'h00C0;
            CH_DEGREE: return 16'hEC00;
            CH_PCT:    return 16'hB300;
            CH_ALL:    return 16'hFFDD;
            default: ;
        endcase
        if (code >= 8'h30 && code <= 8'h39) return DIGIT_SEG[code - 8'h30];
        if (code >= 8'h41 && code <= 8'h5A) return ALPHA_SEG[code - 8'h41];
        if (code >= 8'h61 && code <= 8'h7A) return ALPHA_SEG[code - 8'h61];
        return 16'h0000;
    endfunction

    // Scatter one glyph into the model of the display RAM.
    function automatic void scatter_glyph(input logic [7:0] code, input logic pt,
                                          input logic col, input logic [2:0] slot);
        logic [15:0] g;
        logic [3:0]  nib;
        int          loc;
        int          w;
        g = seg_glyph(code);
        if (pt) g = g | DP_SEG;
        if (col) g = g | COLON_SEG;
        if (slot < 3'd6) begin
            for (int k = 0; k < 4; k++) begin
                nib = g[15 - 4*k -: 4];
                for (int b = 0; b < 4; b++) begin
                    loc = SEG_BIT_MAP[slot][b];
                    w = (2*k + loc / 32) % slcd_pkg::NUM_WORDS;
                    lcd_ram[w][loc % 32] = nib[b];
                end
            end
        end
    endfunction

    task automatic send_char(input logic [7:0] code, input logic pt, input logic col,
                             input logic [2:0] slot, input logic blank_exp);
        t_word_exp e;
        @(negedge clk);
        in_ch.valid      = 1'b1;
        in_ch.char_code  = code;
        in_ch.dot_en     = pt;
        in_ch.col_en     = col;
        in_ch.digit_slot = slot;
        do @(posedge clk); while (!in_ch.ready);
        scatter_glyph(code, pt, col, slot);
        for (int k = 0; k < slcd_pkg::NUM_WORDS; k++) begin
            e.idx   = k[slcd_pkg::IDX_W-1:0];
            e.value = blank_exp ? '0 : lcd_ram[k];
            e.last  = (k == slcd_pkg::NUM_WORDS - 1);
            word_q.push_back(e);
        end
        chars_sent++;
    endtask

    task automatic pause_sender(input int gap);
        if (gap > 0) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 20) return 8'h41 + 8'($urandom_range(0, 25));
        if (r < 35) return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 55) return 8'h30 + 8'($urandom_range(0, 9));
        if (r < 75) return SYMBOL_CODES[$urandom_range(0, 10)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: random back-pressure, calm stretches, one long hold.
    initial begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                out_ch.ready = 1'b0;
                stall_left   = HOLD_LEN - 1;
            end else begin
                int r;
                r = $urandom_range(99);
                if (calm || r < 65) begin
                    out_ch.ready = 1'b1;
                end else if (r < 95) begin
                    out_ch.ready = 1'b0;
                    stall_left   = $urandom_range(0, 2);
                end else begin
                    out_ch.ready = 1'b0;
                    stall_left   = $urandom_range(10, 30);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (word_q.size() == 0) begin
                $display("%0t: unexpected word idx=%0d value=%08h last=%0b", $time,
                         out_ch.word_index, out_ch.word_value, out_ch.last_word);
                err_cnt++;
            end else begin
                t_word_exp e;
                e = word_q.pop_front();
                words_checked++;
                if (out_ch.word_index !== e.idx || out_ch.word_value !== e.value ||
                    out_ch.last_word !== e.last) begin
                    $display("%0t: exp idx=%0d val=%08h last=%0b got idx=%0d val=%08h last=%0b",
                             $time, e.idx, e.value, e.last, out_ch.word_index,
                             out_ch.word_value, out_ch.last_word);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: give up after too long with no transaction on either side.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired, %0d words outstanding", $time, word_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int burst_left;
        logic [2:0] slot;
        err_cnt          = 0;
        chars_sent       = 0;
        words_checked    = 0;
        calm             = 1'b0;
        hold_req         = 1'b0;
        burst_left       = 0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.char_code  = '0;
        in_ch.dot_en     = 1'b0;
        in_ch.col_en     = 1'b0;
        in_ch.digit_slot = '0;
        for (int k = 0; k < slcd_pkg::NUM_WORDS; k++) lcd_ram[k] = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (int n = 0; n < N_DIR; n++) begin
            send_char(DIR_ROWS[n].code, DIR_ROWS[n].pt, DIR_ROWS[n].col,
                      DIR_ROWS[n].slot, DIR_ROWS[n].blank_exp);
            pause_sender(pick_gap());
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = ((n / 40) % 3 == 1);
            if (n == 150) begin
                hold_req   = 1'b1;
                burst_left = 12;
            end
            slot = ($urandom_range(99) < 85) ? 3'($urandom_range(0, 5))
                                             : 3'($urandom_range(6, 7));
            send_char(pick_code(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      slot, 1'b0);
            if (calm || burst_left > 0) begin
                if (burst_left > 0) burst_left--;
            end else begin
                pause_sender(pick_gap());
            end
        end
        @(negedge clk);
        in_ch.valid = 1'b0;

        while (word_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d characters (directed and random), %0d display words checked.",
                 chars_sent, words_checked);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
